// ===== rtl/rsi_pkg.sv =====
// Shared types, widths and codes of the ray / sphere intersection pipeline.
package rsi_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int RADIUS_W  = 31;
    localparam int CNT_W     = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int MUL_CHUNK = 12;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

    // Register word index taken from paddr above the byte offset.
    localparam logic [ADDR_W-3:0] REG_RADIUS = '0;

    // Width of A, B and C; C may go as low as minus the squared radius.
    localparam int SUM_W  = (2 * COORD_W + 2 > 2 * RADIUS_W + 2) ?
                            2 * COORD_W + 2 : 2 * RADIUS_W + 2;
    localparam int DIFF_W = 2 * SUM_W + 1;
    localparam int X_W    = DIFF_W - 1 + 2 * FRAC_BITS;
    localparam int SQ_W   = (X_W + 1) / 2;
    localparam int NUM_W  = ((SQ_W + 1 > SUM_W + FRAC_BITS) ?
                            SQ_W + 1 : SUM_W + FRAC_BITS) + 2;
    localparam int MAG_W  = ((NUM_W > SUM_W) ? NUM_W : SUM_W) + 1;

    localparam logic [1:0] ROOTS_NONE = 2'd0;
    localparam logic [1:0] ROOTS_ONE  = 2'd1;
    localparam logic [1:0] ROOTS_TWO  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic                      hit;
        logic [1:0]                root_count;
        logic signed [COORD_W-1:0] t_near;
        logic signed [COORD_W-1:0] t_far;
        logic [CNT_W-1:0]          tests_total;
        logic [CNT_W-1:0]          hits_total;
    } t_hit;

    typedef struct packed {
        logic azero;
        logic dneg;
        logic dzero;
    } t_flags;

endpackage

// ===== rtl/rsi_dmul.sv =====
// Pipelined signed product difference a1*b1 - a2*b2, one chunk of b per stage.
module rsi_dmul #(
    parameter int AW  = 66,
    parameter int BW  = 66,
    parameter int SBW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [AW-1:0]       i_a1,
    input  logic signed [BW-1:0]       i_b1,
    input  logic signed [AW-1:0]       i_a2,
    input  logic signed [BW-1:0]       i_b2,
    input  logic [SBW-1:0]             i_sb,
    output logic                       o_valid,
    output logic signed [AW+BW:0]      o_p,
    output logic [SBW-1:0]             o_sb
);
    localparam int CH  = rsi_pkg::MUL_CHUNK;
    localparam int NCH = (BW + CH - 1) / CH;
    localparam int PBW = NCH * CH;
    localparam int OW  = AW + BW + 1;

    logic                 r_v   [NCH];
    logic signed [AW-1:0] r_a1  [NCH];
    logic signed [BW-1:0] r_b1  [NCH];
    logic signed [AW-1:0] r_a2  [NCH];
    logic signed [BW-1:0] r_b2  [NCH];
    logic signed [OW-1:0] r_acc [NCH];
    logic [SBW-1:0]       r_sb  [NCH];

    for (genvar k = 0; k < NCH; k++) begin : g_stage
        logic                 c_v;
        logic signed [AW-1:0] c_a1;
        logic signed [BW-1:0] c_b1;
        logic signed [AW-1:0] c_a2;
        logic signed [BW-1:0] c_b2;
        logic signed [OW-1:0] c_acc;
        logic [SBW-1:0]       c_sb;
        logic signed [PBW-1:0] w_bp1;
        logic signed [PBW-1:0] w_bp2;
        logic [CH-1:0]         w_ch1;
        logic [CH-1:0]         w_ch2;
        logic signed [CH:0]    w_c1;
        logic signed [CH:0]    w_c2;
        logic signed [AW+CH:0] w_p1;
        logic signed [AW+CH:0] w_p2;
        logic signed [OW-1:0]  n_acc;

        if (k == 0) begin : g_first
            assign c_v   = i_valid;
            assign c_a1  = i_a1;
            assign c_b1  = i_b1;
            assign c_a2  = i_a2;
            assign c_b2  = i_b2;
            assign c_acc = '0;
            assign c_sb  = i_sb;
        end else begin : g_next
            assign c_v   = r_v[k-1];
            assign c_a1  = r_a1[k-1];
            assign c_b1  = r_b1[k-1];
            assign c_a2  = r_a2[k-1];
            assign c_b2  = r_b2[k-1];
            assign c_acc = r_acc[k-1];
            assign c_sb  = r_sb[k-1];
        end

        assign w_bp1 = PBW'(c_b1);
        assign w_bp2 = PBW'(c_b2);
        assign w_ch1 = w_bp1[k*CH +: CH];
        assign w_ch2 = w_bp2[k*CH +: CH];

        // The top chunk carries the sign of b; the lower ones are unsigned.
        if (k == NCH - 1) begin : g_top
            assign w_c1 = $signed({w_ch1[CH-1], w_ch1});
            assign w_c2 = $signed({w_ch2[CH-1], w_ch2});
        end else begin : g_low
            assign w_c1 = $signed({1'b0, w_ch1});
            assign w_c2 = $signed({1'b0, w_ch2});
        end

        assign w_p1  = c_a1 * w_c1;
        assign w_p2  = c_a2 * w_c2;
        assign n_acc = c_acc + ((OW'(w_p1) - OW'(w_p2)) <<< (k * CH));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a1[k]  <= c_a1;
                r_b1[k]  <= c_b1;
                r_a2[k]  <= c_a2;
                r_b2[k]  <= c_b2;
                r_acc[k] <= n_acc;
                r_sb[k]  <= c_sb;
            end
        end
    end

    assign o_valid = r_v[NCH-1];
    assign o_p     = r_acc[NCH-1];
    assign o_sb    = r_sb[NCH-1];

endmodule

// ===== rtl/rsi_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rsi_sqrt #(
    parameter int XW  = 164,
    parameter int SBW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [XW-1:0]           i_x,
    input  logic [SBW-1:0]          i_sb,
    output logic                    o_valid,
    output logic [(XW+1)/2-1:0]     o_root,
    output logic [SBW-1:0]          o_sb
);
    localparam int SQW = (XW + 1) / 2;
    localparam int PW  = 2 * SQW;
    localparam int RW  = SQW + 3;

    logic           r_v    [SQW];
    logic [RW-1:0]  r_rem  [SQW];
    logic [SQW-1:0] r_root [SQW];
    logic [PW-1:0]  r_x    [SQW];
    logic [SBW-1:0] r_sb   [SQW];

    for (genvar j = 0; j < SQW; j++) begin : g_stage
        logic           c_v;
        logic [RW-1:0]  c_rem;
        logic [SQW-1:0] c_root;
        logic [PW-1:0]  c_x;
        logic [SBW-1:0] c_sb;
        logic [RW-1:0]  w_cat;
        logic [RW-1:0]  w_trial;
        logic [RW-1:0]  n_rem;
        logic [SQW-1:0] n_root;

        if (j == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_x    = PW'(i_x);
            assign c_sb   = i_sb;
        end else begin : g_next
            assign c_v    = r_v[j-1];
            assign c_rem  = r_rem[j-1];
            assign c_root = r_root[j-1];
            assign c_x    = r_x[j-1];
            assign c_sb   = r_sb[j-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign w_cat   = {c_rem[RW-3:0], c_x[PW-1 -: 2]};
        assign w_trial = {1'b0, c_root, 2'b01};

        always_comb begin
            if (w_cat >= w_trial) begin
                n_rem  = w_cat - w_trial;
                n_root = {c_root[SQW-2:0], 1'b1};
            end else begin
                n_rem  = w_cat;
                n_root = {c_root[SQW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
                r_x[j]    <= c_x << 2;
                r_sb[j]   <= c_sb;
            end
        end
    end

    assign o_valid = r_v[SQW-1];
    assign o_root  = r_root[SQW-1];
    assign o_sb    = r_sb[SQW-1];

endmodule

// ===== rtl/rsi_div.sv =====
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
module rsi_div #(
    parameter int MW  = 86,
    parameter int DW  = 66,
    parameter int QW  = 32,
    parameter int SBW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [1:0][MW-1:0]      i_num,
    input  logic [DW-1:0]           i_den,
    input  logic [SBW-1:0]          i_sb,
    output logic                    o_valid,
    output logic [1:0][QW-1:0]      o_q,
    output logic [SBW-1:0]          o_sb
);
    localparam int CW = ((MW > DW + QW) ? MW : DW + QW) + 1;

    logic                 r_v   [QW];
    logic [1:0][CW-1:0]   r_rem [QW];
    logic [1:0][QW-1:0]   r_q   [QW];
    logic [DW-1:0]        r_den [QW];
    logic [SBW-1:0]       r_sb  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic               c_v;
        logic [1:0][CW-1:0] c_rem;
        logic [1:0][QW-1:0] c_q;
        logic [DW-1:0]      c_den;
        logic [SBW-1:0]     c_sb;
        logic [CW-1:0]      w_trial;
        logic [1:0][CW-1:0] n_rem;
        logic [1:0][QW-1:0] n_q;

        if (j == 0) begin : g_first
            assign c_v   = i_valid;
            assign c_rem = {CW'(i_num[1]), CW'(i_num[0])};
            assign c_q   = '0;
            assign c_den = i_den;
            assign c_sb  = i_sb;
        end else begin : g_next
            assign c_v   = r_v[j-1];
            assign c_rem = r_rem[j-1];
            assign c_q   = r_q[j-1];
            assign c_den = r_den[j-1];
            assign c_sb  = r_sb[j-1];
        end

        assign w_trial = CW'(c_den) << K;

        // Both lanes try the same shifted divisor.
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                if (c_rem[l] >= w_trial) begin
                    n_rem[l] = c_rem[l] - w_trial;
                    n_q[l]   = c_q[l] | (QW'(1) << K);
                end else begin
                    n_rem[l] = c_rem[l];
                    n_q[l]   = c_q[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_den[j] <= c_den;
                r_sb[j]  <= c_sb;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

// ===== rtl/rsi_skid.sv =====
// Output register with a one-entry skid buffer behind it.
module rsi_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rsi_pkg::t_hit i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rsi_pkg::t_hit o_data
);
    logic          r_ov;
    logic          r_full;
    rsi_pkg::t_hit r_out;
    rsi_pkg::t_hit r_skid;

    assign o_ready = !r_full;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_full <= 1'b0;
        end else if (i_ready || !r_ov) begin
            if (r_full) begin
                r_ov   <= 1'b1;
                r_full <= 1'b0;
            end else begin
                r_ov <= i_valid;
            end
        end else if (i_valid && !r_full) begin
            r_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_ov) begin
            if (r_full) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid && !r_full) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== rtl/ray_sphere_intersect.sv =====
// Ray / sphere intersection pipeline: one ray transfer per clock while the skid buffer
// has room. The sphere sits at the origin with its radius in the single APB register
// (word 0, unsigned Q15.16, reset 1.0). Each ray gives one result: hit, root count and
// the two roots in ascending order, saturated to Q16.16, plus running counts of tests
// and hits. The stages in series are: two for the dot products, six for the
// discriminant multiply (12 bits of the multiplier operand per stage), one to prepare
// the radicand, 82 for the bit-serial square root (one root bit each), two to form the
// root numerators, 32 for the two-lane divider (one quotient bit each) and the output
// register. Every stage moves on the same enable, so a stalled output freezes the
// whole pipe without losing or repeating a ray.
module ray_sphere_intersect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Ray input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rsi_pkg::t_ray                     i_in_data,
    // Result output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rsi_pkg::t_hit                     o_out_data,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rsi_pkg::ADDR_W-1:0]        paddr,
    input  logic [rsi_pkg::DATA_W-1:0]        pwdata,
    output logic [rsi_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    localparam int W    = rsi_pkg::COORD_W;
    localparam int F    = rsi_pkg::FRAC_BITS;
    localparam int RADW = rsi_pkg::RADIUS_W;
    localparam int SW   = rsi_pkg::SUM_W;
    localparam int DFW  = rsi_pkg::DIFF_W;
    localparam int XW   = rsi_pkg::X_W;
    localparam int SQW  = rsi_pkg::SQ_W;
    localparam int NW   = rsi_pkg::NUM_W;
    localparam int MW   = rsi_pkg::MAG_W;
    localparam int FLW  = $bits(rsi_pkg::t_flags);
    localparam int DSBW = 1 + 2 + 2;

    localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};

    // ---------------------------------------------------------------------------------
    // Configuration register. pready is tied high, so every access completes in its
    // access phase. Only the word index is decoded; writes to other words are dropped.
    // ---------------------------------------------------------------------------------
    logic [RADW-1:0] r_radius;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= rsi_pkg::RADIUS_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[rsi_pkg::ADDR_W-1:2] == rsi_pkg::REG_RADIUS) begin
            r_radius <= pwdata[RADW-1:0];
        end
    end

    always_comb begin
        unique case (paddr[rsi_pkg::ADDR_W-1:2])
            rsi_pkg::REG_RADIUS: prdata = rsi_pkg::DATA_W'(r_radius);
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Global advance. The whole pipe moves while the skid buffer has room, so the
    // ready seen upstream comes straight from a register.
    // ---------------------------------------------------------------------------------
    logic en;
    assign o_in_ready = en;

    // Stage 1: the nine coordinate products and the squared radius.
    logic                  r1_v;
    logic signed [2*W-1:0] r1_dd [3];
    logic signed [2*W-1:0] r1_do [3];
    logic signed [2*W-1:0] r1_oo [3];
    logic [2*RADW-1:0]     r1_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dd[0] <= $signed(i_in_data.dir_x) * $signed(i_in_data.dir_x);
            r1_dd[1] <= $signed(i_in_data.dir_y) * $signed(i_in_data.dir_y);
            r1_dd[2] <= $signed(i_in_data.dir_z) * $signed(i_in_data.dir_z);
            r1_do[0] <= $signed(i_in_data.dir_x) * $signed(i_in_data.origin_x);
            r1_do[1] <= $signed(i_in_data.dir_y) * $signed(i_in_data.origin_y);
            r1_do[2] <= $signed(i_in_data.dir_z) * $signed(i_in_data.origin_z);
            r1_oo[0] <= $signed(i_in_data.origin_x) * $signed(i_in_data.origin_x);
            r1_oo[1] <= $signed(i_in_data.origin_y) * $signed(i_in_data.origin_y);
            r1_oo[2] <= $signed(i_in_data.origin_z) * $signed(i_in_data.origin_z);
            r1_rr    <= r_radius * r_radius;
        end
    end

    // Stage 2: the quadratic coefficients A = d.d, B = d.o (half of b) and
    // C = o.o - r^2, kept exactly.
    logic                 r2_v;
    logic signed [SW-1:0] r2_a;
    logic signed [SW-1:0] r2_b;
    logic signed [SW-1:0] r2_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a <= SW'(r1_dd[0]) + SW'(r1_dd[1]) + SW'(r1_dd[2]);
            r2_b <= SW'(r1_do[0]) + SW'(r1_do[1]) + SW'(r1_do[2]);
            r2_c <= SW'(r1_oo[0]) + SW'(r1_oo[1]) + SW'(r1_oo[2])
                  - SW'($signed({1'b0, r1_rr}));
        end
    end

    // Discriminant D = B*B - A*C; its sign equals the sign of b^2 - 4ac.
    logic                  dm_v;
    logic signed [DFW-1:0] dm_d;
    logic [2*SW-1:0]       dm_sb;

    rsi_dmul #(
        .AW  (SW),
        .BW  (SW),
        .SBW (2 * SW)
    ) u_dmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_a1    (r2_b),
        .i_b1    (r2_b),
        .i_a2    (r2_a),
        .i_b2    (r2_c),
        .i_sb    ({r2_a, r2_b}),
        .o_valid (dm_v),
        .o_p     (dm_d),
        .o_sb    (dm_sb)
    );

    // Stage 3: classify the discriminant and scale it so that the square root comes
    // out with the fraction bits of the roots.
    logic signed [SW-1:0] w3_a;
    logic signed [SW-1:0] w3_b;
    rsi_pkg::t_flags      n3_fl;

    assign {w3_a, w3_b} = dm_sb;
    assign n3_fl.azero  = (w3_a == '0);
    assign n3_fl.dneg   = dm_d[DFW-1];
    assign n3_fl.dzero  = (dm_d == '0);

    logic                 r3_v;
    logic [XW-1:0]        r3_x;
    logic signed [SW-1:0] r3_a;
    logic signed [SW-1:0] r3_b;
    rsi_pkg::t_flags      r3_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= dm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x  <= n3_fl.dneg ? '0 : (XW'(dm_d[DFW-2:0]) << (2 * F));
            r3_a  <= w3_a;
            r3_b  <= w3_b;
            r3_fl <= n3_fl;
        end
    end

    // Square root of the scaled discriminant, rounded down.
    logic                     sq_v;
    logic [SQW-1:0]           sq_s;
    logic [2*SW+FLW-1:0]      sq_sb;

    rsi_sqrt #(
        .XW  (XW),
        .SBW (2 * SW + FLW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_x     (r3_x),
        .i_sb    ({r3_a, r3_b, r3_fl}),
        .o_valid (sq_v),
        .o_root  (sq_s),
        .o_sb    (sq_sb)
    );

    // Stage 4: root numerators -B*2^F - s (near) and -B*2^F + s (far). A far
    // numerator below zero means the sphere lies behind the ray.
    logic signed [SW-1:0] w4_a;
    logic signed [SW-1:0] w4_b;
    rsi_pkg::t_flags      w4_fl;
    logic signed [NW-1:0] w4_bs;
    logic signed [NW-1:0] w4_s;
    logic signed [NW-1:0] n4_nf;
    logic signed [NW-1:0] n4_nn;

    assign {w4_a, w4_b, w4_fl} = sq_sb;
    assign w4_bs = NW'(w4_b) <<< F;
    assign w4_s  = $signed(NW'(sq_s));
    assign n4_nf = w4_s - w4_bs;
    assign n4_nn = -w4_bs - w4_s;

    logic                 r4_v;
    logic signed [NW-1:0] r4_nf;
    logic signed [NW-1:0] r4_nn;
    logic signed [SW-1:0] r4_a;
    logic                 r4_hit;
    logic [1:0]           r4_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_nf  <= n4_nf;
            r4_nn  <= n4_nn;
            r4_a   <= w4_a;
            r4_hit <= !w4_fl.azero && !w4_fl.dneg && !n4_nf[NW-1];
            r4_cnt <= w4_fl.dzero ? rsi_pkg::ROOTS_ONE : rsi_pkg::ROOTS_TWO;
        end
    end

    // Stage 5: floor division of a negative numerator is done on its magnitude
    // rounded up, |n| + A - 1, and the quotient negated afterwards.
    logic [1:0][MW-1:0] n5_m;
    logic [1:0]         n5_neg;

    assign n5_neg[0] = r4_nn[NW-1];
    assign n5_neg[1] = r4_nf[NW-1];
    assign n5_m[0]   = n5_neg[0] ? MW'(-r4_nn) + MW'(r4_a) - MW'(1) : MW'(r4_nn);
    assign n5_m[1]   = n5_neg[1] ? MW'(-r4_nf) + MW'(r4_a) - MW'(1) : MW'(r4_nf);

    logic               r5_v;
    logic [1:0][MW-1:0] r5_m;
    logic [1:0]         r5_neg;
    logic [SW-1:0]      r5_a;
    logic               r5_hit;
    logic [1:0]         r5_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_m   <= n5_m;
            r5_neg <= n5_neg;
            r5_a   <= r4_a;
            r5_hit <= r4_hit;
            r5_cnt <= r4_cnt;
        end
    end

    // Both roots divided by A in parallel lanes: lane 0 near, lane 1 far. The top
    // quotient bit flags a magnitude that needs saturation.
    logic              dv_v;
    logic [1:0][W-1:0] dv_q;
    logic [DSBW-1:0]   dv_sb;

    rsi_div #(
        .MW  (MW),
        .DW  (SW),
        .QW  (W),
        .SBW (DSBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_num   (r5_m),
        .i_den   (r5_a),
        .i_sb    ({r5_hit, r5_cnt, r5_neg}),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_sb    (dv_sb)
    );

    // Final step: sign, saturation, miss masking and the running counters. The
    // counters advance in ray order as each result leaves the divider.
    function automatic logic signed [W-1:0] f_sat(input logic neg, input logic [W-1:0] q);
        logic signed [W-1:0] v;
        if (q[W-1]) begin
            v = neg ? T_MIN : T_MAX;
        end else begin
            v = neg ? -$signed(q) : $signed(q);
        end
        return v;
    endfunction

    logic                    w6_hit;
    logic [1:0]              w6_cnt;
    logic [1:0]              w6_neg;
    logic [rsi_pkg::CNT_W-1:0] r_tests;
    logic [rsi_pkg::CNT_W-1:0] r_hits;
    rsi_pkg::t_hit           n_res;

    assign {w6_hit, w6_cnt, w6_neg} = dv_sb;

    always_comb begin
        n_res.hit         = w6_hit;
        n_res.root_count  = w6_hit ? w6_cnt : rsi_pkg::ROOTS_NONE;
        n_res.t_near      = w6_hit ? f_sat(w6_neg[0], dv_q[0]) : '0;
        n_res.t_far       = w6_hit ? f_sat(w6_neg[1], dv_q[1]) : '0;
        n_res.tests_total = r_tests + rsi_pkg::CNT_W'(1);
        n_res.hits_total  = r_hits + rsi_pkg::CNT_W'(w6_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tests <= '0;
            r_hits  <= '0;
        end else if (en && dv_v) begin
            r_tests <= n_res.tests_total;
            r_hits  <= n_res.hits_total;
        end
    end

    rsi_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_v),
        .o_ready (en),
        .i_data  (n_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
